FILE: rtl/bam_pkg.sv
// Package with types and constants for the block-average mosaic.
package bam_pkg;

  localparam int unsigned MaxBlockColumns = 256;
  localparam int unsigned Channels        = 4;
  localparam int unsigned ChanW           = 16;
  localparam int unsigned SumW            = 32;
  localparam int unsigned AreaW           = 17;

  localparam logic [1:0] RegBlockWidth   = 2'd0;
  localparam logic [1:0] RegBlockHeight  = 2'd1;
  localparam logic [1:0] RegBlocksAcross = 2'd2;
  localparam logic [1:0] RegBlocksDown   = 2'd3;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic [15:0] red_avg;
    logic [15:0] green_avg;
    logic [15:0] blue_avg;
    logic [15:0] alpha_avg;
    logic [7:0]  block_column;
    logic [11:0] block_row;
    logic        frame_done;
  } result_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDiv,
    StOut
  } state_e;

endpackage

FILE: rtl/block_average_mosaic.sv
// Top level of the block-average mosaic accumulator.
// Pixels arrive in raster order; four 32-bit sums per block column sit in one
// synchronous memory of MAX_BLOCK_COLUMNS entries, each 128 bits wide. Each
// pixel item that does not finish a block passes through StRead: the accept
// edge also reads the memory, and StRead adds and writes back, so the next
// pixel can be taken once the block is back in StIdle. The pixel that
// finishes a block then runs a shared restoring divider in StDiv, one
// quotient bit a cycle for all four channels in parallel, and StOut loads the
// output register. The next pixel can be taken from the same cycle in which
// that result item is first offered.
// The next pixel is accepted while a result still waits to be taken, but not
// while a division runs; a finishing pixel whose result finds the output
// register still full waits in the last stage until that item is taken.
// Registers are written through an APB-style port at byte addresses 0, 4, 8
// and 12; values out of range are clamped when used. The sum memory needs no
// clearing: the first pixel of each block loads its column's sums.
module block_average_mosaic
  import bam_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_COLUMNS = MaxBlockColumns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pixel_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = (MAX_BLOCK_COLUMNS > 1) ? $clog2(MAX_BLOCK_COLUMNS) : 1;
  localparam int unsigned MaxCols = (MAX_BLOCK_COLUMNS < 256) ? MAX_BLOCK_COLUMNS : 256;

  // Configuration registers.
  logic [8:0]  bw_reg_q, bh_reg_q, across_reg_q;
  logic [11:0] down_reg_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_reg_q     <= 9'd8;
      bh_reg_q     <= 9'd8;
      across_reg_q <= 9'd1;
      down_reg_q   <= 12'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegBlockWidth:   bw_reg_q     <= pwdata[8:0];
        RegBlockHeight:  bh_reg_q     <= pwdata[8:0];
        RegBlocksAcross: across_reg_q <= pwdata[8:0];
        RegBlocksDown:   down_reg_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegBlockWidth:   prdata[8:0]  = bw_reg_q;
      RegBlockHeight:  prdata[8:0]  = bh_reg_q;
      RegBlocksAcross: prdata[8:0]  = across_reg_q;
      RegBlocksDown:   prdata[11:0] = down_reg_q;
      default: ;
    endcase
  end

  // Clamped working values.
  logic [8:0]  bw, bh, across;
  logic [11:0] down;
  always_comb begin
    bw     = (bw_reg_q == '0) ? 9'd1 : ((bw_reg_q > 9'd256) ? 9'd256 : bw_reg_q);
    bh     = (bh_reg_q == '0) ? 9'd1 : ((bh_reg_q > 9'd256) ? 9'd256 : bh_reg_q);
    across = (across_reg_q == '0) ? 9'd1 :
             ((across_reg_q > 9'(MaxCols)) ? 9'(MaxCols) : across_reg_q);
    down   = (down_reg_q == '0) ? 12'd1 : down_reg_q;
  end

  // Position counters.
  logic [7:0]  px_q, col_q, row_q;
  logic [11:0] brow_q;

  // Sum memory.
  logic [Channels*SumW-1:0] mem [MAX_BLOCK_COLUMNS];
  logic [Channels*SumW-1:0] rd_q;

  state_e      state_q, state_d;
  pixel_t      pix_q;
  logic        first_q, fin_q, fdone_q;
  logic [7:0]  ocol_q;
  logic [11:0] obrow_q;
  logic [AddrW-1:0] addr_q;

  // Divider state.
  logic [SumW-1:0] num_q [Channels];
  logic [AreaW-1:0] rem_q [Channels];
  logic [AreaW-1:0] area_q;
  logic [5:0]       cnt_q;

  result_t res_q;
  logic    ovalid_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;

  wire accept = in_valid_i && in_ready_o;

  // Position decisions for the accepted pixel.
  wire last_x    = ({1'b0, px_q} + 9'd1) >= bw;
  wire last_row  = ({1'b0, row_q} + 9'd1) >= bh;
  wire last_col  = ({1'b0, col_q} + 9'd1) >= across;
  wire last_brow = ({1'b0, brow_q} + 13'd1) >= {1'b0, down};

  // Summed values.
  logic [Channels*SumW-1:0] new_sum;
  always_comb begin
    logic [ChanW-1:0] v;
    for (int c = 0; c < Channels; c++) begin
      v = pix_q[(Channels-1-c)*ChanW +: ChanW];
      new_sum[c*SumW +: SumW] = first_q ? {16'd0, v} : rd_q[c*SumW +: SumW] + {16'd0, v};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StRead;
      StRead: state_d = fin_q ? StDiv : StIdle;
      StDiv:  if (cnt_q == 6'd31) state_d = StOut;
      StOut:  if (!ovalid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      px_q     <= '0;
      col_q    <= '0;
      row_q    <= '0;
      brow_q   <= '0;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      if (state_q == StDiv) cnt_q <= cnt_q + 6'd1;
      else cnt_q <= '0;
      if (accept) begin
        if (last_x) begin
          px_q <= '0;
          if (last_col) begin
            col_q <= '0;
            if (last_row) begin
              row_q  <= '0;
              brow_q <= last_brow ? 12'd0 : brow_q + 12'd1;
            end else begin
              row_q <= row_q + 8'd1;
            end
          end else begin
            col_q <= col_q + 8'd1;
          end
        end else begin
          px_q <= px_q + 8'd1;
        end
      end
    end
  end

  // Payload registers and memory. The column counter never reaches
  // MAX_BLOCK_COLUMNS, so it addresses the memory directly.
  always_ff @(posedge clk_i) begin
    logic [AreaW-1:0] trial;
    if (accept) begin
      pix_q   <= in_data_i;
      first_q <= (px_q == '0) && (row_q == '0);
      fin_q   <= last_x && last_row;
      fdone_q <= last_col && last_brow;
      ocol_q  <= col_q;
      obrow_q <= brow_q;
      addr_q  <= AddrW'(col_q);
      area_q  <= AreaW'(bw) * AreaW'(bh);
      rd_q    <= mem[AddrW'(col_q)];
    end
    if (state_q == StRead) begin
      mem[addr_q] <= new_sum;
      for (int c = 0; c < Channels; c++) begin
        num_q[c] <= new_sum[c*SumW +: SumW];
        rem_q[c] <= '0;
      end
    end
    if (state_q == StDiv) begin
      for (int c = 0; c < Channels; c++) begin
        trial = {rem_q[c][AreaW-2:0], num_q[c][SumW-1]};
        if ({rem_q[c][AreaW-1], trial} >= {1'b0, area_q}) begin
          rem_q[c] <= AreaW'({rem_q[c][AreaW-1], trial} - {1'b0, area_q});
          num_q[c] <= {num_q[c][SumW-2:0], 1'b1};
        end else begin
          rem_q[c] <= trial;
          num_q[c] <= {num_q[c][SumW-2:0], 1'b0};
        end
      end
    end
    if (state_q == StOut && (!ovalid_q || out_ready_i)) begin
      res_q.red_avg      <= (num_q[0][31:16] != '0) ? 16'hFFFF : num_q[0][15:0];
      res_q.green_avg    <= (num_q[1][31:16] != '0) ? 16'hFFFF : num_q[1][15:0];
      res_q.blue_avg     <= (num_q[2][31:16] != '0) ? 16'hFFFF : num_q[2][15:0];
      res_q.alpha_avg    <= (num_q[3][31:16] != '0) ? 16'hFFFF : num_q[3][15:0];
      res_q.block_column <= ocol_q;
      res_q.block_row    <= obrow_q;
      res_q.frame_done   <= fdone_q;
    end
  end

endmodule

FILE: tb/block_average_mosaic_tb.sv
// Self-checking testbench for the block-average mosaic accumulator.
module block_average_mosaic_tb;
  import bam_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // slowest legitimate gap is a full division plus a long random receiver
  // stall, so this is generous.
  localparam int unsigned HangLimit = 5000;
  // Quiet time allowed after the last result before the registers are touched
  // or the run ends; it covers the read, add and divide stages.
  localparam int unsigned SettleCycles = 48;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  pixel_t      in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  result_t     out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  block_average_mosaic u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Pixels waiting to be offered, and block averages waiting to come out.
  pixel_t      pixel_q[$];
  result_t     avg_expect_q[$];

  // Copy of the programmed registers and of the block's position and sums.
  logic [8:0]  cfg_width;
  logic [8:0]  cfg_height;
  logic [8:0]  cfg_across;
  logic [11:0] cfg_down;
  logic [31:0] col_sums[MaxBlockColumns][Channels];
  int unsigned x_in_block;
  int unsigned block_col;
  int unsigned row_in_block;
  int unsigned block_row;

  int unsigned errors;
  int unsigned pixels_taken;
  int unsigned averages_seen;
  int unsigned phases_run;
  int unsigned hang_count;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  logic        in_took;
  logic        hold_input;

  // A zero register acts as one, and a value above the limit acts as the limit.
  function automatic int unsigned used_value(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Advances the position model by one pixel and queues the block average
  // when that pixel is the bottom-right one of its block.
  function automatic void accumulate_pixel(pixel_t p);
    int unsigned bw;
    int unsigned bh;
    int unsigned across;
    int unsigned down;
    logic [15:0] chan[Channels];
    logic [31:0] quot;
    logic        first;
    logic        last_x;
    logic        last_row;
    logic        last_col;
    logic        last_brow;
    result_t     r;
    logic [15:0] avg[Channels];
    bw        = used_value(cfg_width, 256);
    bh        = used_value(cfg_height, 256);
    across    = used_value(cfg_across, (MaxBlockColumns < 256) ? MaxBlockColumns : 256);
    down      = used_value(cfg_down, 4095);
    chan[0]   = p.red_in;
    chan[1]   = p.green_in;
    chan[2]   = p.blue_in;
    chan[3]   = p.alpha_in;
    first     = (x_in_block == 0) && (row_in_block == 0);
    last_x    = x_in_block + 1 >= bw;
    last_row  = row_in_block + 1 >= bh;
    last_col  = block_col + 1 >= across;
    last_brow = block_row + 1 >= down;
    for (int c = 0; c < Channels; c++) begin
      col_sums[block_col][c] = first ? 32'(chan[c]) : col_sums[block_col][c] + chan[c];
    end
    if (last_x && last_row) begin
      for (int c = 0; c < Channels; c++) begin
        quot   = col_sums[block_col][c] / (bw * bh);
        avg[c] = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
      end
      r.red_avg      = avg[0];
      r.green_avg    = avg[1];
      r.blue_avg     = avg[2];
      r.alpha_avg    = avg[3];
      r.block_column = block_col[7:0];
      r.block_row    = block_row[11:0];
      r.frame_done   = last_col && last_brow;
      avg_expect_q.push_back(r);
    end
    if (last_x) begin
      x_in_block = 0;
      if (last_col) begin
        block_col = 0;
        if (last_row) begin
          row_in_block = 0;
          block_row    = last_brow ? 0 : block_row + 1;
        end else begin
          row_in_block++;
        end
      end else begin
        block_col++;
      end
    end else begin
      x_in_block++;
    end
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch in %s: got %0d, expected %0d (block %0d)", field, got, want,
             averages_seen);
    errors++;
  endtask

  // Driver: pixels are offered at the falling edge; a pending pixel stays put
  // until the rising edge at which it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (!hold_input && pixel_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_data_i  <= pixel_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin
    result_t want;
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accumulate_pixel(in_data_i);
        pixels_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (avg_expect_q.size() == 0) begin
          $display("unexpected block average at column %0d row %0d",
                   out_data_o.block_column, out_data_o.block_row);
          errors++;
        end else begin
          want = avg_expect_q.pop_front();
          if (out_data_o.red_avg != want.red_avg)
            report_mismatch("red_avg", out_data_o.red_avg, want.red_avg);
          if (out_data_o.green_avg != want.green_avg)
            report_mismatch("green_avg", out_data_o.green_avg, want.green_avg);
          if (out_data_o.blue_avg != want.blue_avg)
            report_mismatch("blue_avg", out_data_o.blue_avg, want.blue_avg);
          if (out_data_o.alpha_avg != want.alpha_avg)
            report_mismatch("alpha_avg", out_data_o.alpha_avg, want.alpha_avg);
          if (out_data_o.block_column != want.block_column)
            report_mismatch("block_column", out_data_o.block_column, want.block_column);
          if (out_data_o.block_row != want.block_row)
            report_mismatch("block_row", out_data_o.block_row, want.block_row);
          if (out_data_o.frame_done != want.frame_done)
            report_mismatch("frame_done", out_data_o.frame_done, want.frame_done);
        end
        averages_seen++;
      end
      // Watchdog: any accepted item restarts the count.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        hang_count <= 0;
      end else if (hang_count >= HangLimit) begin
        $display("timeout after %0d quiet cycles", hang_count);
        $display("tb: failure");
        $finish;
      end else begin
        hang_count <= hang_count + 1;
      end
    end
  end

  // One register write: setup cycle, then access cycle; the write lands at the
  // rising edge of the access cycle, where the model is updated too.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegBlockWidth:   cfg_width  = value[8:0];
      RegBlockHeight:  cfg_height = value[8:0];
      RegBlocksAcross: cfg_across = value[8:0];
      default:         cfg_down   = value[11:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every pending pixel is taken and every block average has
  // arrived, then lets the datapath drain.
  task automatic drain();
    while (pixel_q.size() > 0 || in_valid_i || avg_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly random channel values, with the two extremes mixed in often.
  function automatic logic [15:0] random_channel();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red_in   = random_channel();
    p.green_in = random_channel();
    p.blue_in  = random_channel();
    p.alpha_in = random_channel();
    return p;
  endfunction

  // Programs a frame geometry and queues whole frames of random pixels, so
  // that the registers never change in the middle of a frame.
  task automatic run_frames(int unsigned w, int unsigned h, int unsigned a,
                            int unsigned d, int unsigned frames);
    int unsigned count;
    drain();
    write_reg(RegBlockWidth, w);
    write_reg(RegBlockHeight, h);
    write_reg(RegBlocksAcross, a);
    write_reg(RegBlocksDown, d);
    count = used_value(w, 256) * used_value(h, 256) * used_value(a, MaxBlockColumns)
            * used_value(d, 4095) * frames;
    repeat (count) pixel_q.push_back(random_pixel());
    phases_run++;
  endtask

  initial begin
    pixel_t p;
    int unsigned wv;
    int unsigned hv;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_took      = 1'b0;
    hold_input   = 1'b0;
    errors       = 0;
    pixels_taken = 0;
    averages_seen = 0;
    phases_run   = 0;
    hang_count   = 0;
    in_idle_pct  = 33;
    out_idle_pct = 47;
    cfg_width    = 9'd8;
    cfg_height   = 9'd8;
    cfg_across   = 9'd1;
    cfg_down     = 12'd1;
    x_in_block   = 0;
    block_col    = 0;
    row_in_block = 0;
    block_row    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry first: one 8x8 block, no register written yet.
    repeat (64) pixel_q.push_back(random_pixel());

    // Directed: a row of two 2x2 blocks. The left block starts with two
    // saturated pixels and the right one with two empty pixels; both end on
    // the same mixed pixels.
    run_frames(2, 2, 2, 1, 0);
    for (int i = 0; i < 8; i++) begin
      p = (i < 4) ? {4{(i < 2) ? 16'hFFFF : 16'h0000}} : random_pixel();
      if (i >= 4) p = {16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
      pixel_q.push_back(p);
    end
    // Zero registers act as one: a single-pixel block per item.
    run_frames(0, 0, 0, 0, 6);
    // Over-range width and height clamp to 256.
    run_frames(511, 1, 1, 1, 1);
    in_idle_pct  = 47;
    out_idle_pct = 33;
    run_frames(1, 300, 1, 1, 1);

    // Random geometries, mostly small blocks and grids.
    while (pixels_taken + pixel_q.size() < 700) begin
      wv = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 4);
      hv = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      run_frames(wv, hv, $urandom_range(1, 5), $urandom_range(1, 3), $urandom_range(1, 2));
      // Now and then stop the input entirely until everything has come out.
      if ($urandom_range(3) == 0) begin
        hold_input = 1'b1;
        while (avg_expect_q.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_input = 1'b0;
      end
    end

    // Column extremes with one-pixel blocks and no idling: the widest grid,
    // with one stop of the input part way through, then its over-range clamp.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_frames(1, 1, 256, 1, 1);
    repeat (100) @(posedge clk_i);
    hold_input = 1'b1;
    while (avg_expect_q.size() > 0 || in_valid_i) @(posedge clk_i);
    hold_input = 1'b0;
    run_frames(1, 1, 300, 1, 1);
    drain();

    $display("ran %0d geometries: %0d pixels in, %0d block averages out",
             phases_run, pixels_taken, averages_seen);
    $display("covered zero and over-range registers, blocks up to 256 pixels, 256 columns");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
